// ===== hdl/lzss_ring_image_decoder_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the LZSS ring image decoder
// Concurrent assertion shorthands, one clock and one reset per use.
// ---------------------------------------------------------------------------
`ifndef LZSS_RING_IMAGE_DECODER_TOP_MACROS_SVH
`define LZSS_RING_IMAGE_DECODER_TOP_MACROS_SVH

// Same-cycle implication
`define LZSR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define LZSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/lzsr_pkg.sv =====
// ---------------------------------------------------------------------------
// lzsr_pkg
// Shared types and constants of the LZSS ring image decoder.
// ---------------------------------------------------------------------------
package lzsr_pkg;

   // Ring size exponent default
   localparam int WINDOW_BITS_DEFAULT = 12;

   // Command queue between parser and copy engine
   localparam int QUEUE_DEPTH = 4;

   // Register file
   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;
   localparam logic [CSR_W-1:0] IMAGE_WIDTH_RESET  = 13'd320;
   localparam logic [CSR_W-1:0] IMAGE_HEIGHT_RESET = 13'd200;

   // Token format
   localparam int DIST_BITS     = 12;
   localparam int LEN_W         = 5;
   localparam int MATCH_LEN_MIN = 3;
   localparam logic [7:0] FLAG_SENTINEL = 8'h80;
   localparam logic [7:0] FLAG_EMPTY    = 8'h01;

   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_LITERAL = 2'd1,
      CMD_MATCH   = 2'd2
   } cmd_kind_type;

   // One queued command: optional frame restart, then a token
   typedef struct packed {
      logic         restart;
      cmd_kind_type kind;
      logic [15:0]  data;
   } cmd_type;

endpackage

// ===== hdl/lzsr_front.sv =====
// ---------------------------------------------------------------------------
// lzsr_front
// Token parser: takes compressed bytes, tracks flag bits and match halves,
// and pushes literal, match and restart commands into the queue.
// ---------------------------------------------------------------------------
module lzsr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   input  logic              req_frame_start,
   input  logic              q_full,
   output logic              q_push,
   output lzsr_pkg::cmd_type q_push_cmd
);

   typedef enum logic [3:0] {
      PH_FLAG    = 4'b0001,
      PH_LITERAL = 4'b0010,
      PH_HIGH    = 4'b0100,
      PH_LOW     = 4'b1000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] flag_ff, flag_in;
   logic [7:0] high_ff, high_in;

   phase_type  cur_phase;
   phase_type  tok_phase;
   logic [7:0] cur_flag;
   logic [7:0] flag_shift;
   logic       accept;

   // Parse one byte per accepted handshake
   always_comb begin
      accept     = req_valid && !q_full;
      req_ready  = !q_full;
      cur_phase  = req_frame_start ? PH_FLAG : phase_ff;
      cur_flag   = req_frame_start ? lzsr_pkg::FLAG_EMPTY : flag_ff;
      flag_shift = {1'b0, cur_flag[7:1]};
      if (flag_shift == 8'h00) begin
         tok_phase = PH_FLAG;
      end else begin
         tok_phase = cur_flag[0] ? PH_HIGH : PH_LITERAL;
      end

      phase_in   = phase_ff;
      flag_in    = flag_ff;
      high_in    = high_ff;
      q_push     = 1'b0;
      q_push_cmd.restart = req_frame_start;
      q_push_cmd.kind    = lzsr_pkg::CMD_NONE;
      q_push_cmd.data    = {8'h00, req_in_byte};

      if (accept) begin
         case (cur_phase)
            PH_FLAG: begin
               flag_in  = lzsr_pkg::FLAG_SENTINEL | {1'b0, req_in_byte[7:1]};
               phase_in = req_in_byte[0] ? PH_HIGH : PH_LITERAL;
               q_push   = req_frame_start;
            end
            PH_LITERAL: begin
               q_push          = 1'b1;
               q_push_cmd.kind = lzsr_pkg::CMD_LITERAL;
               flag_in         = flag_shift;
               phase_in        = tok_phase;
            end
            PH_HIGH: begin
               high_in  = req_in_byte;
               phase_in = PH_LOW;
               q_push   = req_frame_start;
            end
            PH_LOW: begin
               q_push          = 1'b1;
               q_push_cmd.kind = lzsr_pkg::CMD_MATCH;
               q_push_cmd.data = {high_ff, req_in_byte};
               flag_in         = flag_shift;
               phase_in        = tok_phase;
            end
            default: begin
               phase_in = PH_FLAG;
            end
         endcase
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FLAG;
         flag_ff  <= lzsr_pkg::FLAG_EMPTY;
      end else begin
         phase_ff <= phase_in;
         flag_ff  <= flag_in;
      end
   end

   // Match high byte needs no reset
   always_ff @(posedge clock) begin
      high_ff <= high_in;
   end

endmodule

// ===== hdl/lzsr_queue.sv =====
// ---------------------------------------------------------------------------
// lzsr_queue
// Small command FIFO that decouples the parser from the copy engine.
// ---------------------------------------------------------------------------
module lzsr_queue #(
   parameter int DEPTH = lzsr_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lzsr_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output lzsr_pkg::cmd_type head_cmd
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   lzsr_pkg::cmd_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   // Advance pointers and count
   always_comb begin
      full       = (count_ff == CW'(DEPTH));
      head_valid = (count_ff != '0);
      head_cmd   = entry_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/lzsr_back.sv =====
// ---------------------------------------------------------------------------
// lzsr_back
// Copy engine: emits literals, copies matches out of the history ring,
// writes every pixel back to the ring and tracks row and frame position.
// ---------------------------------------------------------------------------
`include "lzss_ring_image_decoder_top_macros.svh"

module lzsr_back #(
   parameter int WINDOW_BITS = lzsr_pkg::WINDOW_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [lzsr_pkg::CSR_W-1:0] cfg_width,
   input  logic [lzsr_pkg::CSR_W-1:0] cfg_height,
   input  logic                       q_valid,
   input  lzsr_pkg::cmd_type          q_cmd,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_pixel,
   output logic                       rsp_row_end,
   output logic                       rsp_frame_end,
   output logic                       rsp_last_of_run
);

   localparam int RING_SIZE = 1 << WINDOW_BITS;
   localparam int DW  = (WINDOW_BITS > lzsr_pkg::DIST_BITS + 1) ?
                        WINDOW_BITS : lzsr_pkg::DIST_BITS + 1;
   localparam int CW  = lzsr_pkg::CSR_W;
   localparam int LW  = lzsr_pkg::LEN_W;
   localparam int WB  = WINDOW_BITS;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_COPY = 2'b10
   } back_state_type;

   // History ring and its read port
   logic [7:0] ring_mem [RING_SIZE];
   logic [7:0] rdata_ff;
   logic       rvalid_ff;
   logic       byp_ff;
   logic [7:0] byp_data_ff;

   back_state_type state_ff, state_in;
   logic [WB-1:0]  ptr_ff, ptr_in;
   logic [WB:0]    fill_ff, fill_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [CW-1:0]  row_ff, row_in;
   logic           done_ff, done_in;
   logic [WB-1:0]  src_ff, src_in;
   logic [LW-1:0]  rem_ff, rem_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     pixel_ff, pixel_in;
   logic           row_end_ff, row_end_in;
   logic           frame_end_ff, frame_end_in;
   logic           last_ff, last_in;

   logic           slot_free;
   logic           take;
   logic           restart_now;
   logic [WB-1:0]  base_ptr;
   logic [CW-1:0]  base_col;
   logic [CW-1:0]  base_row;
   logic           base_done;
   logic [CW-1:0]  w_eff;
   logic [CW-1:0]  h_eff;
   logic           re;
   logic           fe;
   logic [DW-1:0]  dist_ext;
   logic [LW-1:0]  match_len;
   logic [WB-1:0]  src0;
   logic [7:0]     rd_data;
   logic           emit_fire;
   logic [7:0]     emit_val;
   logic           emit_last;
   logic           rd_en;
   logic [WB-1:0]  raddr;
   logic           byp_in;
   logic [WB:0]    ptr_ff_ext;

   // Decode command, run copy, update ring position and pixel counters
   always_comb begin
      slot_free   = !rsp_valid_ff || rsp_ready;
      w_eff       = (cfg_width == '0) ? CW'(1) : cfg_width;
      h_eff       = (cfg_height == '0) ? CW'(1) : cfg_height;
      rd_data     = byp_ff ? byp_data_ff : (rvalid_ff ? rdata_ff : 8'h00);
      ptr_ff_ext  = {1'b0, ptr_ff};

      take        = q_valid && (state_ff == ST_IDLE) &&
                    ((q_cmd.kind != lzsr_pkg::CMD_LITERAL) || slot_free);
      q_pop       = take;
      restart_now = take && q_cmd.restart;
      base_ptr    = restart_now ? '0 : ptr_ff;
      base_col    = restart_now ? '0 : col_ff;
      base_row    = restart_now ? '0 : row_ff;
      base_done   = restart_now ? 1'b0 : done_ff;

      dist_ext    = DW'(q_cmd.data[lzsr_pkg::DIST_BITS-1:0]) + DW'(1);
      match_len   = LW'(q_cmd.data[15:lzsr_pkg::DIST_BITS]) + LW'(lzsr_pkg::MATCH_LEN_MIN);
      src0        = base_ptr - dist_ext[WB-1:0];

      re = ({1'b0, base_col} + (CW+1)'(1)) >= {1'b0, w_eff};
      fe = re && (({1'b0, base_row} + (CW+1)'(1)) >= {1'b0, h_eff});

      state_in     = state_ff;
      ptr_in       = base_ptr;
      fill_in      = fill_ff;
      col_in       = base_col;
      row_in       = base_row;
      done_in      = base_done;
      src_in       = src_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pixel_in     = pixel_ff;
      row_end_in   = row_end_ff;
      frame_end_in = frame_end_ff;
      last_in      = last_ff;
      emit_fire    = 1'b0;
      emit_val     = q_cmd.data[7:0];
      emit_last    = 1'b1;
      rd_en        = 1'b0;
      raddr        = src_ff;

      case (state_ff)
         ST_IDLE: begin
            // Drop tokens once the frame is complete
            if (take && !base_done) begin
               case (q_cmd.kind)
                  lzsr_pkg::CMD_LITERAL: begin
                     emit_fire = 1'b1;
                     emit_val  = q_cmd.data[7:0];
                     emit_last = 1'b1;
                  end
                  lzsr_pkg::CMD_MATCH: begin
                     rd_en    = 1'b1;
                     raddr    = src0;
                     src_in   = src0 + WB'(1);
                     rem_in   = match_len;
                     state_in = ST_COPY;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_COPY: begin
            // One match byte per cycle while the output slot frees up
            if (slot_free) begin
               emit_fire = 1'b1;
               emit_val  = rd_data;
               emit_last = (rem_ff == LW'(1)) || fe;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en  = 1'b1;
                  raddr  = src_ff;
                  src_in = src_ff + WB'(1);
                  rem_in = rem_ff - LW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Write back the pixel and step the counters
      if (emit_fire) begin
         ptr_in       = base_ptr + WB'(1);
         if ({1'b0, base_ptr} == fill_ff) begin
            fill_in = fill_ff + (WB+1)'(1);
         end
         rsp_valid_in = 1'b1;
         pixel_in     = emit_val;
         row_end_in   = re;
         frame_end_in = fe;
         last_in      = emit_last;
         if (fe) begin
            col_in  = '0;
            row_in  = '0;
            done_in = 1'b1;
         end else if (re) begin
            col_in = '0;
            row_in = base_row + CW'(1);
         end else begin
            col_in = base_col + CW'(1);
         end
      end

      byp_in = emit_fire && (base_ptr == raddr);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      rem_ff       <= rem_in;
      pixel_ff     <= pixel_in;
      row_end_ff   <= row_end_in;
      frame_end_ff <= frame_end_in;
      last_ff      <= last_in;
   end

   // Ring: one write, one registered read; forward a same-cycle write,
   // and read unwritten entries as zero via the fill count
   always_ff @(posedge clock) begin
      if (emit_fire) begin
         ring_mem[base_ptr] <= emit_val;
      end
      if (rd_en) begin
         rdata_ff    <= ring_mem[raddr];
         rvalid_ff   <= {1'b0, raddr} < fill_ff;
         byp_ff      <= byp_in;
         byp_data_ff <= emit_val;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel       = pixel_ff;
   assign rsp_row_end     = row_end_ff;
   assign rsp_frame_end   = frame_end_ff;
   assign rsp_last_of_run = last_ff;

   `LZSR_ASSERT_IMPL(a_emit_needs_slot, clock, reset, emit_fire, slot_free, "emit with full output")
   `LZSR_ASSERT_IMPL(a_copy_has_bytes, clock, reset, state_ff == ST_COPY, rem_ff != '0, "copy with no bytes left")
   `LZSR_ASSERT_IMPL(a_fill_covers_ptr, clock, reset, 1'b1, ptr_ff_ext <= fill_ff, "write pointer beyond fill")
   `LZSR_ASSERT_NEXT(a_frame_end_stops, clock, reset, emit_fire && fe, done_ff && (state_ff == ST_IDLE), "frame end did not stop copy")

endmodule

// ===== hdl/lzss_ring_image_decoder_top.sv =====
// ---------------------------------------------------------------------------
// lzss_ring_image_decoder_top
// LZSS image decoder with a history ring: parser, command queue, copy engine
// and the image size registers.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_in_byte, req_frame_start
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_pixel, rsp_row_end,
//           |           |                      | rsp_frame_end, rsp_last_of_run
//   csr     | in        | csr_we               | csr_index, csr_wdata
//
// Flag and match high bytes are absorbed in the parser; a literal taken
// from the queue head leaves the copy engine through its output register.
// A match starts with one read of the ring's single registered read port,
// then yields one pixel per cycle while the output slot is free.
// No clearing pass after reset: a fill count makes unwritten entries read 0.
// Output stalls hold the copy; the four-entry queue lets the parser take
// bytes meanwhile, and a full queue drops req_ready.
// ---------------------------------------------------------------------------
module lzss_ring_image_decoder_top #(
   parameter int WINDOW_BITS = lzsr_pkg::WINDOW_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_in_byte,
   input  logic                           req_frame_start,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_pixel,
   output logic                           rsp_row_end,
   output logic                           rsp_frame_end,
   output logic                           rsp_last_of_run,
   input  logic                           csr_we,
   input  logic [lzsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lzsr_pkg::CSR_W-1:0]     csr_wdata
);

   logic [lzsr_pkg::CSR_W-1:0] width_ff, width_in;
   logic [lzsr_pkg::CSR_W-1:0] height_ff, height_in;

   logic              q_push;
   lzsr_pkg::cmd_type q_push_cmd;
   logic              q_full;
   logic              q_pop;
   logic              q_valid;
   lzsr_pkg::cmd_type q_head;

   // Decode register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            lzsr_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            lzsr_pkg::CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lzsr_pkg::IMAGE_WIDTH_RESET;
         height_ff <= lzsr_pkg::IMAGE_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   lzsr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_frame_start (req_frame_start),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_push_cmd      (q_push_cmd)
   );

   lzsr_queue #(
      .DEPTH (lzsr_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head)
   );

   lzsr_back #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg_width       (width_ff),
      .cfg_height      (height_ff),
      .q_valid         (q_valid),
      .q_cmd           (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel       (rsp_pixel),
      .rsp_row_end     (rsp_row_end),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
